>>> src/bhs_pkg.sv
// Shared constants, codes and helpers for the bucketed hash set.
`timescale 1ns / 1ps
`default_nettype none
package bhs_pkg;

	// default sizes
	localparam int NUM_BUCKETS_DEF = 64;
	localparam int SLOTS_DEF       = 8;
	localparam int KEY_WIDTH_DEF   = 31;

	// fixed field widths
	localparam int FUNC_W         = 2;
	localparam int STATUS_W       = 2;
	localparam int BUCKET_INDEX_W = 6;
	localparam int CFG_W          = 7;
	localparam int OUT_TDATA_W    = 16;

	localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 7'd64;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam func_t FUNC_SEARCH = 2'd0;
	localparam func_t FUNC_INSERT = 2'd1;
	localparam func_t FUNC_DELETE = 2'd2;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_MISS = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	// zero reads as one, anything above the table size saturates
	function automatic int clamp_count(input logic [CFG_W-1:0] v, input int num_buckets);
		int r;
		r = int'(v);
		if (r == 0) begin
			r = 1;
		end else if (r > num_buckets) begin
			r = num_buckets;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/bhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/bhs_mod.sv
// Restoring remainder unit: one dividend bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module bhs_mod #(
	parameter int DIVIDEND_W = 31,
	parameter int DIVISOR_W  = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output      logic                  busy,
	output      logic [DIVISOR_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    den_ext;

	assign busy      = (cnt_q != '0);
	assign remainder = rem_q;
	assign trial     = {rem_q, num_q[DIVIDEND_W-1]};
	assign den_ext   = {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIVIDEND_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// rem stays below den, so trial < 2*den and one subtract is enough
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= num_q << 1;
			if (trial >= den_ext) begin
				rem_q <= DIVISOR_W'(trial - den_ext);
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

>>> src/bucketed_hash_set_unit.sv
// Top level: key set in a bucketed hash table, search / insert / delete per request.
//
//  channel   dir  handshake             payload
//  s_axis    in   s_tvalid / s_tready   s_tdata: func, key
//  m_axis    out  m_tvalid / m_tready   m_tdata: status, found, bucket_index
//  cfg       in   cfg_we                cfg_wdata: bucket_count
//
// A request passes through the bit-serial remainder unit, valid row read and latch, a key
// RAM read and compare for each slot, write-back and done before its result is loaded.
// s_tready is high only while the sequencer is idle, so a new request is not taken
// until the previous one has left done. A finished result waits in the output
// register and the next request is taken meanwhile; a second result stalls in done.
// Reset and a bucket_count write clear all the per-bucket live flags at once.
`timescale 1ns / 1ps
`default_nettype none
module bucketed_hash_set_unit #(
	parameter int NUM_BUCKETS = bhs_pkg::NUM_BUCKETS_DEF,
	parameter int SLOTS       = bhs_pkg::SLOTS_DEF,
	parameter int KEY_WIDTH   = bhs_pkg::KEY_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	// [1:0] func, [KEY_WIDTH+1:2] key, zero fill above
	input  wire logic [((KEY_WIDTH+2+7)/8)*8-1:0]  s_tdata,
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	// [1:0] status, [2] found, [8:3] bucket_index, zero fill above
	output      logic [bhs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [bhs_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int DEPTH = NUM_BUCKETS * SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int BKW   = $clog2(NUM_BUCKETS);
	localparam int CW    = $clog2(NUM_BUCKETS + 1);
	localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BC_RST = bhs_pkg::clamp_count(bhs_pkg::BUCKET_COUNT_RST, NUM_BUCKETS);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MOD  = 8'b0000_0010,
		S_RDV  = 8'b0000_0100,
		S_LATV = 8'b0000_1000,
		S_KRD  = 8'b0001_0000,
		S_KCMP = 8'b0010_0000,
		S_WR   = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          bc_q;
	logic [NUM_BUCKETS-1:0] live_q;
	bhs_pkg::func_t         func_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [SLOTS-1:0]       vrow_q;
	logic [SIW-1:0]         idx_q;
	logic                   match_q;
	logic [SIW-1:0]         match_idx_q;
	logic                   free_q;
	logic [SIW-1:0]         free_idx_q;
	logic                   m_tvalid_q;
	logic [bhs_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic                   accept;
	logic                   div_busy;
	logic [CW-1:0]          rem;
	logic [BKW-1:0]         bucket;
	logic [AW-1:0]          key_raddr;
	logic [AW-1:0]          key_waddr;
	logic [KEY_WIDTH-1:0]   key_rdata;
	logic [SLOTS-1:0]       vrow_rdata;
	logic                   do_ins;
	logic                   do_del;
	logic [SLOTS-1:0]       vrow_wdata;
	logic                   slot_hit;
	bhs_pkg::status_t       status;
	logic                   out_load;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign bucket   = rem[BKW-1:0];

	assign key_raddr = AW'(int'(bucket) * SLOTS + int'(idx_q));
	assign key_waddr = AW'(int'(bucket) * SLOTS + int'(free_idx_q));

	assign do_ins = (state_q == S_WR) && (func_q == bhs_pkg::FUNC_INSERT) && free_q;
	assign do_del = (state_q == S_WR) && (func_q == bhs_pkg::FUNC_DELETE) && match_q;

	always_comb begin
		vrow_wdata = vrow_q;
		if (do_ins) begin
			vrow_wdata[free_idx_q] = 1'b1;
		end else begin
			vrow_wdata[match_idx_q] = 1'b0;
		end
	end

	assign slot_hit = vrow_q[idx_q] && (key_rdata == key_q);

	always_comb begin
		case (func_q)
			bhs_pkg::FUNC_INSERT: status = free_q ? bhs_pkg::ST_OK : bhs_pkg::ST_FULL;
			default:              status = match_q ? bhs_pkg::ST_OK : bhs_pkg::ST_MISS;
		endcase
	end

	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	bhs_mod #(
		.DIVIDEND_W (KEY_WIDTH),
		.DIVISOR_W  (CW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.dividend  (s_tdata[KEY_WIDTH+1:2]),
		.divisor   (bc_q),
		.busy      (div_busy),
		.remainder (rem)
	);

	bhs_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (do_ins),
		.waddr (key_waddr),
		.wdata (key_q),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	// one row of slot valid bits per bucket
	bhs_ram #(
		.WIDTH (SLOTS),
		.DEPTH (NUM_BUCKETS)
	) u_valid_ram (
		.clk   (clk),
		.we    (do_ins || do_del),
		.waddr (bucket),
		.wdata (vrow_wdata),
		.raddr (bucket),
		.rdata (vrow_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bc_q        <= CW'(BC_RST);
			live_q      <= '0;
			idx_q       <= '0;
			match_q     <= 1'b0;
			match_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				bc_q   <= CW'(bhs_pkg::clamp_count(cfg_wdata, NUM_BUCKETS));
				live_q <= '0;
			end else if (do_ins) begin
				live_q[bucket] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (!div_busy) begin
						state_q <= S_RDV;
					end
				end
				S_RDV:  state_q <= S_LATV;
				S_LATV: state_q <= S_KRD;
				S_KRD:  state_q <= S_KCMP;
				S_KCMP: begin
					if (slot_hit && !match_q) begin
						match_q     <= 1'b1;
						match_idx_q <= idx_q;
					end
					if (!vrow_q[idx_q] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (idx_q == SIW'(SLOTS - 1)) begin
						state_q <= S_WR;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_KRD;
					end
				end
				S_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tdata[1:0];
			key_q  <= s_tdata[KEY_WIDTH+1:2];
		end
		// a bucket not written since the last clear reads as empty
		if (state_q == S_LATV) begin
			vrow_q <= live_q[bucket] ? vrow_rdata : '0;
		end
		if (out_load) begin
			m_tdata_q <= bhs_pkg::OUT_TDATA_W'({
				bhs_pkg::BUCKET_INDEX_W'(bucket), match_q, status});
		end
	end

endmodule
`default_nettype wire

>>> dv/bucketed_hash_set_unit_tb.sv
// Self-checking testbench for the bucketed hash set: directed and random search/insert/delete traffic.
`timescale 1ns / 1ps
module bucketed_hash_set_unit_tb;

	localparam int KEY_W       = bhs_pkg::KEY_WIDTH_DEF;
	localparam int NUM_BKT     = bhs_pkg::NUM_BUCKETS_DEF;
	localparam int SLOT_CNT    = bhs_pkg::SLOTS_DEF;
	localparam int S_W         = ((KEY_W + 2 + 7) / 8) * 8;
	localparam int POOL_SIZE   = 20;
	localparam int HOLD_CYCLES = 600;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 120;

	// spare func code, behaves like a search
	localparam bhs_pkg::func_t FUNC_SPARE = 2'd3;

	typedef struct packed {
		bhs_pkg::func_t   func;
		logic [KEY_W-1:0] key;
	} hash_req_t;

	typedef struct packed {
		bhs_pkg::status_t                   status;
		logic                               found;
		logic [bhs_pkg::BUCKET_INDEX_W-1:0] bucket;
	} hash_reply_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [S_W-1:0]                  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [bhs_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            cfg_we;
	logic [bhs_pkg::CFG_W-1:0]       cfg_wdata;

	bucketed_hash_set_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the table
	logic [KEY_W-1:0] slot_key  [NUM_BKT*SLOT_CNT];
	logic             slot_live [NUM_BKT*SLOT_CNT];
	int unsigned      bucket_total;

	hash_req_t        lookup_backlog[$];
	hash_reply_t      predicted_replies[$];
	hash_req_t        in_flight;
	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	int  error_count = 0;
	int  send_gap;
	int  recv_gap;
	int  quiet_cycles;
	logic idle_on;
	logic hold_go;
	logic drain_hold;

	always #5 clk = ~clk;

	task automatic flag_error(input string what, input int got, input int want);
		$display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	function automatic void table_apply(input hash_req_t r);
		int unsigned bkt;
		int base;
		int hit;
		int spare;
		hash_reply_t o;
		bkt   = r.key % bucket_total;
		base  = int'(bkt) * SLOT_CNT;
		hit   = -1;
		spare = -1;
		for (int s = 0; s < SLOT_CNT; s++) begin
			if (slot_live[base+s]) begin
				if (hit < 0 && slot_key[base+s] == r.key)
					hit = s;
			end else if (spare < 0) begin
				spare = s;
			end
		end
		o.found  = (hit >= 0);
		o.bucket = bhs_pkg::BUCKET_INDEX_W'(bkt);
		case (r.func)
			bhs_pkg::FUNC_INSERT: begin
				if (spare >= 0) begin
					slot_key[base+spare]  = r.key;
					slot_live[base+spare] = 1'b1;
					o.status = bhs_pkg::ST_OK;
				end else begin
					o.status = bhs_pkg::ST_FULL;
				end
			end
			bhs_pkg::FUNC_DELETE: begin
				if (hit >= 0) begin
					slot_live[base+hit] = 1'b0;
					o.status = bhs_pkg::ST_OK;
				end else begin
					o.status = bhs_pkg::ST_MISS;
				end
			end
			default: o.status = (hit >= 0) ? bhs_pkg::ST_OK : bhs_pkg::ST_MISS;
		endcase
		predicted_replies = {predicted_replies, o};
	endfunction

	function automatic void table_clear(input logic [bhs_pkg::CFG_W-1:0] v);
		if (v == 0)
			bucket_total = 1;
		else if (v > NUM_BKT)
			bucket_total = NUM_BKT;
		else
			bucket_total = 32'(v);
		for (int i = 0; i < NUM_BKT*SLOT_CNT; i++)
			slot_live[i] = 1'b0;
	endfunction

	function automatic void push_req(input bhs_pkg::func_t f, input logic [KEY_W-1:0] k);
		hash_req_t r;
		r.func = f;
		r.key  = k;
		lookup_backlog = {lookup_backlog, r};
	endfunction

	task automatic wait_quiet();
		@(negedge clk);
		while (lookup_backlog.size() != 0 || s_tvalid || predicted_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_bucket_count(input logic [bhs_pkg::CFG_W-1:0] v);
		wait_quiet();
		repeat (4) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		table_clear(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// keys crowded into a few buckets so chains fill, plus the extremes
	function automatic void refill_pool();
		int unsigned span;
		int unsigned nb;
		int unsigned m;
		int unsigned b;
		span = 32'h7FFF_FFFF / bucket_total;
		nb   = (bucket_total < 4) ? bucket_total : 4;
		for (int i = 0; i < POOL_SIZE; i++) begin
			m = $urandom_range(0, span - 1);
			b = $urandom_range(0, nb - 1);
			key_pool[i] = KEY_W'(m * bucket_total + b);
		end
		key_pool[0]           = '0;
		key_pool[POOL_SIZE-1] = '1;
	endfunction

	function automatic void queue_random(input int n);
		int pick;
		bhs_pkg::func_t f;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				f = bhs_pkg::FUNC_INSERT;
			else if (pick < 70)
				f = bhs_pkg::FUNC_SEARCH;
			else if (pick < 95)
				f = bhs_pkg::FUNC_DELETE;
			else
				f = FUNC_SPARE;
			if ($urandom_range(0, 99) < 80)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = KEY_W'($urandom());
			push_req(f, k);
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			table_apply(in_flight);
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (lookup_backlog.size() != 0) begin
				in_flight = lookup_backlog.pop_front();
				s_tdata  <= {{(S_W-KEY_W-bhs_pkg::FUNC_W){1'b0}}, in_flight.key, in_flight.func};
				s_tvalid <= 1'b1;
				send_gap = idle_on ? $urandom_range(0, 11) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// reply monitor
	always @(posedge clk) begin
		hash_reply_t want;
		if (m_tvalid && m_tready) begin
			if (predicted_replies.size() == 0) begin
				flag_error("reply with no request outstanding", int'(m_tdata), 0);
			end else begin
				want = predicted_replies.pop_front();
				if (m_tdata[1:0] !== want.status)
					flag_error("status", int'(m_tdata[1:0]), int'(want.status));
				if (m_tdata[2] !== want.found)
					flag_error("found", int'(m_tdata[2]), int'(want.found));
				if (m_tdata[8:3] !== want.bucket)
					flag_error("bucket_index", int'(m_tdata[8:3]), int'(want.bucket));
			end
			recv_gap = idle_on ? $urandom_range(0, 11) : 0;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else if (drain_hold) begin
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	initial begin
		drain_hold = 1'b0;
		wait (hold_go);
		@(posedge clk);
		drain_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		drain_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("bucketed_hash_set_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [bhs_pkg::CFG_W-1:0] phase_cfg[8];
		int                        phase_len[8];
		logic                      phase_idle[8];
		phase_cfg  = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd3, 7'd37, 7'd2, 7'd64};
		phase_len  = '{200, 100, 250, 200, 250, 230, 150, 100};
		phase_idle = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		idle_on      = 1'b1;
		hold_go      = 1'b0;
		table_clear(bhs_pkg::BUCKET_COUNT_RST);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass at the reset bucket count
		push_req(bhs_pkg::FUNC_SEARCH, '0);
		push_req(bhs_pkg::FUNC_INSERT, '0);
		push_req(bhs_pkg::FUNC_INSERT, '0);
		push_req(bhs_pkg::FUNC_SEARCH, '0);
		push_req(bhs_pkg::FUNC_INSERT, '1);
		push_req(bhs_pkg::FUNC_SEARCH, '1);
		push_req(FUNC_SPARE, '1);
		push_req(bhs_pkg::FUNC_DELETE, KEY_W'(5));
		push_req(bhs_pkg::FUNC_DELETE, '0);
		push_req(bhs_pkg::FUNC_SEARCH, '0);
		push_req(bhs_pkg::FUNC_DELETE, '0);
		push_req(bhs_pkg::FUNC_SEARCH, '0);
		// fill bucket zero, then overflow it
		for (int i = 1; i <= SLOT_CNT + 1; i++)
			push_req(bhs_pkg::FUNC_INSERT, KEY_W'(i * 64));
		push_req(bhs_pkg::FUNC_INSERT, KEY_W'(64));
		push_req(bhs_pkg::FUNC_DELETE, KEY_W'(64));
		push_req(bhs_pkg::FUNC_INSERT, KEY_W'((SLOT_CNT + 1) * 64));

		for (int p = 0; p < 8; p++) begin
			write_bucket_count(phase_cfg[p]);
			idle_on <= phase_idle[p];
			if (p == 2)
				hold_go <= 1'b1;
			@(negedge clk);
			refill_pool();
			queue_random(phase_len[p]);
		end

		wait_quiet();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (predicted_replies.size() != 0)
			flag_error("replies never returned", 0, predicted_replies.size());
		if (error_count == 0)
			$display("bucketed_hash_set_unit: match");
		else
			$display("bucketed_hash_set_unit: mismatch");
		$finish;
	end

endmodule
